FILE: rtl/dbrn_pkg.sv
// Package for the decimal round-and-normalize block: item types and divide-by-ten constants.
`timescale 1ns / 1ps

package dbrn_pkg;

    localparam int IN_MANT_W  = 224;
    localparam int WORD_W     = 56;
    localparam int RES_W      = 96;
    localparam int SCALE_W    = 8;
    localparam int SCALE_OUT_W = 5;

    // divide-by-ten digit unit: 4-bit remainder above a 16-bit chunk
    localparam int CHUNK_W    = 16;
    localparam int REM_W      = 4;
    localparam int DIV_IN_W   = CHUNK_W + REM_W;
    localparam int RECIP_W    = 20;
    localparam int PROD_W     = DIV_IN_W + RECIP_W;
    localparam int RECIP_SH   = 23;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;
    localparam logic [3:0]         TEN       = 4'd10;
    localparam logic [REM_W-1:0]   HALF_DIGIT = 4'd5;

    typedef struct packed {
        logic [WORD_W-1:0]  mant_w0;
        logic [WORD_W-1:0]  mant_w1;
        logic [WORD_W-1:0]  mant_w2;
        logic [WORD_W-1:0]  mant_w3;
        logic [SCALE_W-1:0] scale_in;
        logic               sign_in;
    } t_in_item;

    typedef struct packed {
        logic [63:0]            res_low;
        logic [31:0]            res_high;
        logic [SCALE_OUT_W-1:0] scale_out;
        logic                   sign_out;
        logic                   status;
    } t_out_item;

endpackage

FILE: rtl/dbrn_div10.sv
// One long-division digit step by ten over a 16-bit chunk with incoming remainder.
`timescale 1ns / 1ps

module dbrn_div10
    import dbrn_pkg::*;
(
    input  logic [REM_W-1:0]   i_rem,
    input  logic [CHUNK_W-1:0] i_chunk,
    output logic [CHUNK_W-1:0] o_quot,
    output logic [REM_W-1:0]   o_rem
);

    logic [DIV_IN_W-1:0] w_num;
    logic [PROD_W-1:0]   w_prod;
    logic [DIV_IN_W-1:0] w_q;
    logic [DIV_IN_W-1:0] w_back;

    always_comb begin
        w_num  = {i_rem, i_chunk};
        w_prod = PROD_W'(w_num) * PROD_W'(RECIP_TEN);
        w_q    = DIV_IN_W'(w_prod >> RECIP_SH);
        w_back = DIV_IN_W'(w_q * DIV_IN_W'(TEN));
        o_quot = w_q[CHUNK_W-1:0];
        o_rem  = REM_W'(w_num - w_back);
    end

endmodule

FILE: rtl/decimal_bankers_round_normalize.sv
// Top level: reduces a wide decimal mantissa to 96 bits with round half to even.
//
// Usage: an item on the input channel carries a 224-bit mantissa in four
// 56-bit words, an 8-bit scale and a sign. It is taken when i_in_valid is high
// and o_in_stall is low. The block works on one item at a time and holds
// o_in_stall high until the item's result has been loaded into the output
// register. The mantissa is divided by ten one 16-bit chunk per cycle by a
// single digit unit, with a check step before each division and after the
// last. The number of divisions is at most the input scale, and an increment
// step follows when rounding adds one. The next item is taken in the cycle
// after a result is loaded. The result sits in an output register with
// o_out_valid; while i_out_stall is high it holds, and the next item may
// already be accepted and worked on, waiting only at its final step. Reset
// (synchronous, active low) returns the sequencer to idle and drops
// o_out_valid.
`timescale 1ns / 1ps

module decimal_bankers_round_normalize
    import dbrn_pkg::*;
#(
    parameter int WIDE_BITS = 224,
    parameter int MAX_SCALE = 28
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int NCH   = (WIDE_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int WB    = NCH * CHUNK_W;
    localparam int PAD_W = (WB > IN_MANT_W) ? WB : IN_MANT_W;
    localparam int CNT_W = $clog2(NCH);
    localparam logic [CNT_W-1:0] LAST_CHUNK = CNT_W'(NCH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DECIDE,
        ST_INC,
        ST_FINISH
    } t_state;

    t_state             r_state;
    logic [WB-1:0]      r_mant;
    logic [SCALE_W-1:0] r_scale;
    logic               r_sign;
    logic [REM_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [PAD_W-1:0]   w_pad;
    logic [WB-1:0]      w_load;
    logic               w_above;
    logic               w_more;
    logic               w_out_load;
    logic [CHUNK_W-1:0] w_quot;
    logic [REM_W-1:0]   w_rem;

    dbrn_div10 u_div10 (
        .i_rem   (r_rem),
        .i_chunk (r_mant[WB-1 -: CHUNK_W]),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    always_comb begin
        w_pad = PAD_W'({i_in_data.mant_w3, i_in_data.mant_w2,
                        i_in_data.mant_w1, i_in_data.mant_w0});
        for (int b = 0; b < WB; b++) begin
            w_load[b] = (b < WIDE_BITS) ? w_pad[b] : 1'b0;
        end
        w_above = (r_mant[WB-1:RES_W] != '0);
        w_more  = (w_above && (r_scale != '0)) || (r_scale > SCALE_W'(MAX_SCALE));
        w_out_load = (r_state == ST_FINISH) && (!r_out_valid || !i_out_stall);
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_rem       <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_mant  <= w_load;
                        r_scale <= i_in_data.scale_in;
                        r_sign  <= i_in_data.sign_in;
                        r_rem   <= '0;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (w_more) begin
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_scale <= r_scale - SCALE_W'(1);
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DIV: begin
                    r_mant <= {r_mant[WB-CHUNK_W-1:0], w_quot};
                    r_rem  <= w_rem;
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == LAST_CHUNK) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_DECIDE: begin
                    if (!w_above && ((r_rem > HALF_DIGIT) ||
                                     ((r_rem == HALF_DIGIT) && r_mant[0]))) begin
                        r_state <= ST_INC;
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_INC: begin
                    r_mant  <= r_mant + WB'(1);
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (w_out_load) begin
                        r_out_data.status    <= w_above;
                        r_out_data.res_low   <= w_above ? '0 : r_mant[63:0];
                        r_out_data.res_high  <= w_above ? '0 : r_mant[RES_W-1:64];
                        r_out_data.scale_out <= r_scale[SCALE_OUT_W-1:0];
                        r_out_data.sign_out  <= r_sign;
                        r_state              <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/decimal_bankers_round_normalize_tb.sv
// Testbench for decimal_bankers_round_normalize: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module decimal_bankers_round_normalize_tb;
    import dbrn_pkg::*;

    localparam int SCALE_CAP   = 28;
    localparam int HOLD_CYCLES = 3000;
    localparam logic [IN_MANT_W-1:0] RES_MAX = IN_MANT_W'({RES_W{1'b1}});
    localparam logic [IN_MANT_W-1:0] ALL_ONES = {IN_MANT_W{1'b1}};
    localparam logic [IN_MANT_W-1:0] TEN_W = IN_MANT_W'(TEN);
    localparam logic [IN_MANT_W-1:0] ONE_W = IN_MANT_W'(1);

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    t_in_item  pending_items[$];
    t_out_item due_results[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        mismatches = 0;
    bit        pressure_go = 1'b0;
    logic      rx_hold = 1'b0;

    decimal_bankers_round_normalize #(
        .WIDE_BITS(IN_MANT_W),
        .MAX_SCALE(SCALE_CAP)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // divide by ten until the mantissa fits and the scale is in range, then round half to even
    function automatic t_out_item predict_rounding(t_in_item it);
        logic [IN_MANT_W-1:0] m;
        logic [REM_W-1:0]     rem;
        int unsigned          sc;
        logic                 ovf;
        t_out_item            r;
        m   = {it.mant_w3, it.mant_w2, it.mant_w1, it.mant_w0};
        rem = '0;
        sc  = 32'(it.scale_in);
        while ((m[IN_MANT_W-1:RES_W] != '0 && sc > 0) || sc > SCALE_CAP) begin
            rem = REM_W'(m % TEN_W);
            m   = m / TEN_W;
            if (sc > 0) sc--;
        end
        ovf = |m[IN_MANT_W-1:RES_W];
        if (!ovf && (rem > HALF_DIGIT || (rem == HALF_DIGIT && m[0]))) begin
            m   = m + ONE_W;
            ovf = |m[IN_MANT_W-1:RES_W];
        end
        r.res_low   = ovf ? '0 : m[63:0];
        r.res_high  = ovf ? '0 : m[95:64];
        r.scale_out = sc[SCALE_OUT_W-1:0];
        r.sign_out  = it.sign_in;
        r.status    = ovf;
        return r;
    endfunction

    function automatic t_in_item make_item(logic [IN_MANT_W-1:0] m, int unsigned sc, bit sg);
        t_in_item it;
        {it.mant_w3, it.mant_w2, it.mant_w1, it.mant_w0} = m;
        it.scale_in = sc[SCALE_W-1:0];
        it.sign_in  = sg;
        return it;
    endfunction

    function automatic logic [IN_MANT_W-1:0] rand_mant(int unsigned len);
        logic [IN_MANT_W-1:0] v;
        for (int i = 0; i < IN_MANT_W; i += 32) v[i +: 32] = $urandom;
        return v & (ALL_ONES >> (IN_MANT_W - len));
    endfunction

    function automatic logic [IN_MANT_W-1:0] pow10(int unsigned k);
        logic [IN_MANT_W-1:0] p;
        p = ONE_W;
        repeat (k) p = p * TEN_W;
        return p;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] exp_v);
        if (got !== exp_v) report_mismatch($sformatf("%s got %h want %h", name, got, exp_v));
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) due_results.push_back(predict_rounding(i_in_data));
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= rx_hold || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item %h", o_out_data));
            end else begin
                want = due_results.pop_front();
                check_field("res_low", o_out_data.res_low, want.res_low);
                check_field("res_high", 64'(o_out_data.res_high), 64'(want.res_high));
                check_field("scale_out", 64'(o_out_data.scale_out), 64'(want.scale_out));
                check_field("sign_out", 64'(o_out_data.sign_out), 64'(want.sign_out));
                check_field("status", 64'(o_out_data.status), 64'(want.status));
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic drain();
        @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || due_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic queue_directed();
        pending_items.push_back(make_item('0, 0, 1'b0));
        pending_items.push_back(make_item(ALL_ONES, 255, 1'b1));
        pending_items.push_back(make_item(ALL_ONES, 0, 1'b0));
        pending_items.push_back(make_item('0, 255, 1'b1));
        pending_items.push_back(make_item(RES_MAX, SCALE_CAP, 1'b1));
        pending_items.push_back(make_item(RES_MAX, SCALE_CAP + 1, 1'b0));
        pending_items.push_back(make_item(IN_MANT_W'(45), SCALE_CAP + 1, 1'b0));   // tie, even quotient
        pending_items.push_back(make_item(IN_MANT_W'(35), SCALE_CAP + 1, 1'b1));   // tie, odd quotient
        pending_items.push_back(make_item(RES_MAX * TEN_W + IN_MANT_W'(6), SCALE_CAP + 1, 1'b0));
        pending_items.push_back(make_item(RES_MAX * TEN_W + IN_MANT_W'(4), SCALE_CAP + 1, 1'b1));
        pending_items.push_back(make_item(RES_MAX * TEN_W + IN_MANT_W'(5), SCALE_CAP + 1, 1'b0));
        pending_items.push_back(make_item(RES_MAX + ONE_W, 1, 1'b0));
        pending_items.push_back(make_item((RES_MAX + ONE_W) << 104, SCALE_CAP, 1'b1));
        pending_items.push_back(make_item('0, SCALE_CAP + 1, 1'b0));
        pending_items.push_back(make_item(IN_MANT_W'(150), SCALE_CAP + 2, 1'b0));
        pending_items.push_back(make_item(IN_MANT_W'(251), SCALE_CAP + 2, 1'b1));  // earlier digits not sticky
        pending_items.push_back(make_item(ALL_ONES ^ (ALL_ONES >> 1), 5, 1'b0));
        pending_items.push_back(make_item(ALL_ONES, 128, 1'b1));
        pending_items.push_back(make_item(RES_MAX + IN_MANT_W'(5), 127, 1'b0));
        pending_items.push_back(make_item(ALL_ONES >> 56, 31, 1'b1));
    endtask

    task automatic queue_random(int n);
        logic [IN_MANT_W-1:0] m;
        logic [IN_MANT_W-1:0] q;
        logic [IN_MANT_W-1:0] p;
        int unsigned          k;
        int unsigned          sc;
        int unsigned          pick;
        int unsigned          dg;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // k divisions down to the scale cap, last digit chosen
                k  = $urandom_range(1, 30);
                p  = pow10(k - 1);
                q  = (pick < 5) ? RES_MAX - IN_MANT_W'($urandom_range(0, 3))
                                : rand_mant($urandom_range(0, RES_W));
                dg = ($urandom_range(0, 2) == 0) ? 32'(HALF_DIGIT) : $urandom_range(0, 9);
                m  = q * p * TEN_W + IN_MANT_W'(dg) * p + rand_mant(IN_MANT_W) % p;
                sc = SCALE_CAP + k;
            end else if (pick < 70) begin
                m  = rand_mant($urandom_range(RES_W - 8, IN_MANT_W));
                sc = $urandom_range(0, SCALE_CAP);
            end else begin
                m  = rand_mant($urandom_range(0, IN_MANT_W));
                sc = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 63);
            end
            pending_items.push_back(make_item(m, sc, 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic run_phase(int n, int send_pct, int recv_pct);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
        queue_random(n);
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        queue_directed();
        drain();
        run_phase(400, 0, 0);
        run_phase(300, 81, 0);
        run_phase(300, 0, 81);
        run_phase(300, 23, 23);
        pressure_go = 1'b1;
        run_phase(150, 0, 0);
        run_phase(300, 0, 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[decimal_bankers_round_normalize] OK");
        end else begin
            $display("[decimal_bankers_round_normalize] ERROR");
        end
        $finish;
    end

    initial begin
        #500_000_000;
        $display("[decimal_bankers_round_normalize] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/dbrn_pkg.sv
rtl/dbrn_div10.sv
rtl/decimal_bankers_round_normalize.sv
tb/decimal_bankers_round_normalize_tb.sv
